// File: sv/zone_bitmap_allocator_core_assert.svh
// Assertion macros for the zone bitmap allocator.
// Used by the top level; expects ports named clock and reset in scope.
`ifndef ZONE_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define ZONE_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define ZBA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("zone bitmap allocator: same-cycle check failed");

// next-cycle implication
`define ZBA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("zone bitmap allocator: next-cycle check failed");

`endif

// File: sv/zba_pkg.sv
// Shared types and constants of the zone bitmap allocator.
// No dependencies; used by every module of the block except zba_ram.
package zba_pkg;

   localparam int MAX_BLOCKS = 8192;
   localparam int MAP_BYTES  = (MAX_BLOCKS + 7) / 8;
   localparam int MAP_ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int CNT_W      = MAP_ADDR_W + 1;
   localparam int OFF_W      = MAP_ADDR_W + 3;
   localparam int BYTE_W     = 8;
   localparam int BLK_W      = 16;
   localparam int ZONE_W     = 14;
   localparam int SPAN_W     = ((ZONE_W > OFF_W) ? ZONE_W : OFF_W) + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [BLK_W-1:0]  FIRST_RESET = '0;
   localparam logic [ZONE_W-1:0] ZONES_RESET = ZONE_W'(8192);

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_BLOCK = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_COUNT  = CSR_IDX_W'(1);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_NO_FREE      = 2'd1,
      ST_RANGE        = 2'd2,
      ST_ALREADY_FREE = 2'd3
   } status_type;

   typedef struct packed {
      logic [BLK_W-1:0]  first_block;
      logic [ZONE_W-1:0] live_zones;
   } cfg_type;

   typedef struct packed {
      logic                  we;
      logic [MAP_ADDR_W-1:0] waddr;
      logic [BYTE_W-1:0]     wdata;
      logic                  re;
      logic [MAP_ADDR_W-1:0] raddr;
   } mem_req_type;

endpackage

// File: sv/zba_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module zba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/zba_csr.sv
// Configuration registers of the zone bitmap allocator.
// Depends on zba_pkg; presents the clamped zone count to the sequencer.
module zba_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [zba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [zba_pkg::CSR_DATA_W-1:0]    csr_data,
   output zba_pkg::cfg_type                  cfg
);

   logic [zba_pkg::BLK_W-1:0]  first_ff;
   logic [zba_pkg::ZONE_W-1:0] zones_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= zba_pkg::FIRST_RESET;
         zones_ff <= zba_pkg::ZONES_RESET;
      end else if (csr_valid) begin
         if (csr_index == zba_pkg::CSR_FIRST_BLOCK) begin
            first_ff <= zba_pkg::BLK_W'(csr_data);
         end else if (csr_index == zba_pkg::CSR_ZONE_COUNT) begin
            zones_ff <= csr_data[zba_pkg::ZONE_W-1:0];
         end
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      cfg.first_block = first_ff;
      if (32'(zones_ff) > zba_pkg::MAX_BLOCKS) begin
         cfg.live_zones = zba_pkg::ZONE_W'(zba_pkg::MAX_BLOCKS);
      end else begin
         cfg.live_zones = zones_ff;
      end
   end

endmodule

// File: sv/zba_seq.sv
// Request sequencer: clearing pass, first-fit byte scan and free check.
// Depends on zba_pkg; drives the bitmap RAM and holds the result register.
module zba_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  zba_pkg::cfg_type                    cfg,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [zba_pkg::BLK_W-1:0]           req_block_number,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [zba_pkg::BLK_W-1:0]           rsp_allocated_block,
   output zba_pkg::mem_req_type                mem_req,
   input  logic [zba_pkg::BYTE_W-1:0]          mem_rdata
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE_RD,
      S_FREE_CHK,
      S_RESP
   } state_type;

   state_type                           state_ff, state_in;
   logic [zba_pkg::MAP_ADDR_W-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [zba_pkg::CNT_W-1:0]           rd_cnt_ff, rd_cnt_in;
   logic                                chk_pend_ff, chk_pend_in;
   logic [zba_pkg::MAP_ADDR_W-1:0]      chk_addr_ff, chk_addr_in;
   logic [zba_pkg::BLK_W-1:0]           blk_ff, blk_in;
   logic [zba_pkg::MAP_ADDR_W-1:0]      fbyte_ff, fbyte_in;
   logic [2:0]                          fbit_ff, fbit_in;
   zba_pkg::status_type                 res_status_ff, res_status_in;
   logic [zba_pkg::BLK_W-1:0]           res_block_ff, res_block_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   zba_pkg::status_type                 rsp_status_ff, rsp_status_in;
   logic [zba_pkg::BLK_W-1:0]           rsp_block_ff, rsp_block_in;

   logic [zba_pkg::CNT_W-1:0]           nbytes;
   logic [zba_pkg::SPAN_W-1:0]          bits_left;
   logic [zba_pkg::BYTE_W-1:0]          valid_mask;
   logic [zba_pkg::BYTE_W-1:0]          free_bits;
   logic [2:0]                          free_idx;
   logic [zba_pkg::BYTE_W-1:0]          set_mask;
   logic [zba_pkg::BLK_W:0]             range_end;
   logic                                in_range;
   logic [zba_pkg::BLK_W-1:0]           blk_off;
   logic [zba_pkg::BYTE_W-1:0]          fbit_mask;

   assign nbytes = zba_pkg::CNT_W'(({1'b0, cfg.live_zones} + 15'd7) >> 3);
   assign bits_left = zba_pkg::SPAN_W'(cfg.live_zones)
                    - zba_pkg::SPAN_W'({chk_addr_ff, 3'b000});

   always_comb begin
      for (int b = 0; b < zba_pkg::BYTE_W; b++) begin
         valid_mask[b] = zba_pkg::SPAN_W'(b) < bits_left;
      end
   end

   assign free_bits = ~mem_rdata & valid_mask;

   always_comb begin
      free_idx = 3'd0;
      for (int b = zba_pkg::BYTE_W - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            free_idx = 3'(b);
         end
      end
   end

   assign set_mask  = zba_pkg::BYTE_W'(1) << free_idx;
   assign fbit_mask = zba_pkg::BYTE_W'(1) << fbit_ff;
   assign range_end = {1'b0, cfg.first_block} + (zba_pkg::BLK_W + 1)'(cfg.live_zones);
   assign in_range  = (blk_ff >= cfg.first_block) && ({1'b0, blk_ff} < range_end);
   assign blk_off   = blk_ff - cfg.first_block;

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      rd_cnt_in     = rd_cnt_ff;
      chk_pend_in   = chk_pend_ff;
      chk_addr_in   = chk_addr_ff;
      blk_in        = blk_ff;
      fbyte_in      = fbyte_ff;
      fbit_in       = fbit_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      mem_req       = '0;
      req_ready     = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_cnt_ff;
            mem_req.wdata = '0;
            clr_cnt_in    = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == zba_pkg::MAP_ADDR_W'(zba_pkg::MAP_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               blk_in      = req_block_number;
               rd_cnt_in   = '0;
               chk_pend_in = 1'b0;
               if (req_cmd == zba_pkg::CMD_FREE) begin
                  state_in = S_FREE_RD;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (chk_pend_ff && (free_bits != '0)) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = chk_addr_ff;
               mem_req.wdata = mem_rdata | set_mask;
               chk_pend_in   = 1'b0;
               res_status_in = zba_pkg::ST_OK;
               res_block_in  = cfg.first_block
                             + zba_pkg::BLK_W'({chk_addr_ff, free_idx});
               state_in      = S_RESP;
            end else if (rd_cnt_ff < nbytes) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = rd_cnt_ff[zba_pkg::MAP_ADDR_W-1:0];
               rd_cnt_in     = rd_cnt_ff + 1'b1;
               chk_pend_in   = 1'b1;
               chk_addr_in   = rd_cnt_ff[zba_pkg::MAP_ADDR_W-1:0];
            end else begin
               chk_pend_in = 1'b0;
               if (!chk_pend_ff) begin
                  res_status_in = zba_pkg::ST_NO_FREE;
                  res_block_in  = '0;
                  state_in      = S_RESP;
               end
            end
         end
         S_FREE_RD: begin
            res_block_in = '0;
            if (in_range) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = blk_off[zba_pkg::OFF_W-1:3];
               fbyte_in      = blk_off[zba_pkg::OFF_W-1:3];
               fbit_in       = blk_off[2:0];
               state_in      = S_FREE_CHK;
            end else begin
               res_status_in = zba_pkg::ST_RANGE;
               state_in      = S_RESP;
            end
         end
         S_FREE_CHK: begin
            if ((mem_rdata & fbit_mask) == '0) begin
               res_status_in = zba_pkg::ST_ALREADY_FREE;
            end else begin
               mem_req.we    = 1'b1;
               mem_req.waddr = fbyte_ff;
               mem_req.wdata = mem_rdata & ~fbit_mask;
               res_status_in = zba_pkg::ST_OK;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_block_in  = res_block_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rd_cnt_ff    <= '0;
         chk_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rd_cnt_ff    <= rd_cnt_in;
         chk_pend_ff  <= chk_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_addr_ff   <= chk_addr_in;
      blk_ff        <= blk_in;
      fbyte_ff      <= fbyte_in;
      fbit_ff       <= fbit_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_allocated_block = rsp_block_ff;

endmodule

// File: sv/zone_bitmap_allocator_core.sv
// Zone bitmap allocator: allocate scans the bitmap in S_SCAN, reading at most 1024 bytes
// (one RAM read per cycle), and returns no-free if none is free. Free reads the byte
// in S_FREE_RD and checks it in S_FREE_CHK (no read when out of range). A new item
// is taken once the result has passed from S_RESP into the output register, while it may
// still wait there. After reset the bitmap RAM is cleared one byte a cycle, all 1024
// bytes; requests wait, configuration writes are taken throughout.
module zone_bitmap_allocator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [zba_pkg::BLK_W-1:0]         req_block_number,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [zba_pkg::BLK_W-1:0]         rsp_allocated_block,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [zba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [zba_pkg::CSR_DATA_W-1:0]    csr_data
);

`include "zone_bitmap_allocator_core_assert.svh"

   zba_pkg::cfg_type                 cfg;
   zba_pkg::mem_req_type             mem_req;
   logic [zba_pkg::BYTE_W-1:0]       mem_rdata;

   zba_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   zba_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_block_number    (req_block_number),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_allocated_block (rsp_allocated_block),
      .mem_req             (mem_req),
      .mem_rdata           (mem_rdata)
   );

   zba_ram #(
      .WIDTH (zba_pkg::BYTE_W),
      .DEPTH (zba_pkg::MAP_BYTES)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .re    (mem_req.re),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

   `ZBA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `ZBA_ASSERT_NOW(a_no_rw_collision, mem_req.we && mem_req.re,
      mem_req.waddr != mem_req.raddr)
   `ZBA_ASSERT_NOW(a_block_zero_on_fail, rsp_valid && (rsp_status != zba_pkg::ST_OK),
      rsp_allocated_block == '0)
   `ZBA_ASSERT_NOW(a_clear_blocks_req, $fell(reset), !req_ready)

endmodule
